>>> rtl/keyboard_matrix_io_port_assert.svh
// ----------------------------------------------------------------------------
// Keyboard matrix I/O port assertion macros
// Shared concurrent assertion forms used by the RTL of the port block.
// ----------------------------------------------------------------------------
`ifndef KEYBOARD_MATRIX_IO_PORT_ASSERT_SVH
`define KEYBOARD_MATRIX_IO_PORT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define KBIO_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kbio assertion failed");

// Next-cycle implication, checked outside reset.
`define KBIO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kbio assertion failed");

`endif

>>> rtl/kbio_pkg.sv
// ----------------------------------------------------------------------------
// Keyboard matrix I/O port package
// Request codes, port addresses and the item types shared by the RTL.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kbio_pkg;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_VIDEO = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  localparam logic [7:0] PORT_CASS   = 8'h00;
  localparam logic [7:0] PORT_ROW_HI = 8'h10;
  localparam logic [7:0] PORT_ROW_LO = 8'h20;
  localparam logic [7:0] PORT_MODS   = 8'h40;

  // Column value that turns on the any-key scan for the key IRQ.
  localparam logic [3:0] COL_SCAN    = 4'hF;
  localparam logic [3:0] NIBBLE_ONES = 4'hF;

  localparam int unsigned ROWS_LOW_W = 64;
  localparam int unsigned ROW_W      = 8;
  localparam int unsigned ROWS_LOW_N = ROWS_LOW_W / ROW_W;

  typedef struct packed {
    req_e                  req_type;
    logic [7:0]            port_addr;
    logic [7:0]            write_data;
    logic                  video_int_level;
    logic [ROWS_LOW_W-1:0] key_rows_low;
    logic [ROW_W-1:0]      key_row_eight;
    logic [3:0]            key_row_nine;
    logic [2:0]            modifier_keys;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       key_irq;
    logic       nmi_pulse;
    logic       cass_motor;
  } out_item_t;

endpackage

`default_nettype wire

>>> rtl/kbio_if.sv
// ----------------------------------------------------------------------------
// Keyboard matrix I/O port channels
// Valid/ready interfaces for the request and result channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface kbio_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [7:0]  port_addr;
  logic [7:0]  write_data;
  logic        video_int_level;
  logic [63:0] key_rows_low;
  logic [7:0]  key_row_eight;
  logic [3:0]  key_row_nine;
  logic [2:0]  modifier_keys;

  modport source (
    output valid, req_type, port_addr, write_data, video_int_level,
           key_rows_low, key_row_eight, key_row_nine, modifier_keys,
    input  ready
  );

  modport sink (
    input  valid, req_type, port_addr, write_data, video_int_level,
           key_rows_low, key_row_eight, key_row_nine, modifier_keys,
    output ready
  );
endinterface

interface kbio_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       key_irq;
  logic       nmi_pulse;
  logic       cass_motor;

  modport source (
    output valid, read_data, key_irq, nmi_pulse, cass_motor,
    input  ready
  );

  modport sink (
    input  valid, read_data, key_irq, nmi_pulse, cass_motor,
    output ready
  );
endinterface

`default_nettype wire

>>> rtl/keyboard_matrix_io_port.sv
// ----------------------------------------------------------------------------
// Keyboard matrix I/O port
// Port read/write and video line sample handling for a scanned keyboard.
// ----------------------------------------------------------------------------
//   channel | dir | beat contents
//   in_i    | in  | req_type, port_addr, write_data, video level, key rows
//   out_o   | out | read_data, key_irq, nmi_pulse, cass_motor
//
// One beat is accepted per cycle while input ready is high; a request is
// held in the request register, then its result in the result register.
// The port state updates when a request moves into the result register.
// A stalled result holds the pipe; the request register takes a beat while
// empty or its beat moves on; input ready returns once the result drains.
// Reset clears all port state at once; there is no memory to sweep.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "keyboard_matrix_io_port_assert.svh"

module keyboard_matrix_io_port (
  input  wire       clk_i,
  input  wire       rst_ni,
  kbio_in_if.sink   in_i,
  kbio_out_if.source out_o
);
  import kbio_pkg::*;

  logic      in_valid_q;
  in_item_t  in_q;
  logic      out_valid_q;
  out_item_t out_q;
  out_item_t result;
  logic      advance;
  logic      step;
  logic      in_accept;

  // The result register frees when it is empty or its beat leaves.
  assign advance   = !out_valid_q || out_o.ready;
  assign step      = in_valid_q && advance;
  assign in_i.ready = !in_valid_q || advance;
  assign in_accept = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q.req_type        <= req_e'(in_i.req_type);
      in_q.port_addr       <= in_i.port_addr;
      in_q.write_data      <= in_i.write_data;
      in_q.video_int_level <= in_i.video_int_level;
      in_q.key_rows_low    <= in_i.key_rows_low;
      in_q.key_row_eight   <= in_i.key_row_eight;
      in_q.key_row_nine    <= in_i.key_row_nine;
      in_q.modifier_keys   <= in_i.modifier_keys;
    end
  end

  kbio_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= result;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.read_data  = out_q.read_data;
  assign out_o.key_irq    = out_q.key_irq;
  assign out_o.nmi_pulse  = out_q.nmi_pulse;
  assign out_o.cass_motor = out_q.cass_motor;

  `KBIO_ASSERT_NEXT(a_accept_fills_req_reg, clk_i, rst_ni, in_accept, in_valid_q)
  `KBIO_ASSERT_NEXT(a_step_fills_result, clk_i, rst_ni, step, out_valid_q)
  `KBIO_ASSERT_NOW(a_backpressure_only_when_full, clk_i, rst_ni,
    !in_i.ready, in_valid_q && out_valid_q && !out_o.ready)

endmodule

`default_nettype wire

>>> rtl/kbio_core.sv
// ----------------------------------------------------------------------------
// Keyboard matrix I/O port core
// Port state registers with the decode, row select and key IRQ logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "keyboard_matrix_io_port_assert.svh"

module kbio_core (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      step_i,
  input  wire kbio_pkg::in_item_t  item_i,
  output kbio_pkg::out_item_t      result_o
);
  import kbio_pkg::*;

  logic [3:0]       col_q, col_d;
  logic             video_last_q, video_last_d;
  logic [ROW_W-1:0] last_or_q, last_or_d;
  logic             irq_q, irq_d;
  logic             cass_q, cass_d;

  logic [ROW_W-1:0] sel_row;
  logic [ROW_W-1:0] any_key;
  logic [7:0]       rdata;
  logic             nmi;

  // Row addressed by the column latch; rows above nine read as no keys.
  always_comb begin
    case (col_q) inside
      [4'd0:4'd7]: sel_row = item_i.key_rows_low[{col_q[2:0], 3'b000} +: ROW_W];
      4'd8:        sel_row = item_i.key_row_eight;
      4'd9:        sel_row = {4'h0, item_i.key_row_nine};
      default:     sel_row = '0;
    endcase
  end

  always_comb begin
    any_key = item_i.key_row_eight;
    for (int r = 0; r < ROWS_LOW_N; r++) begin
      any_key = any_key | item_i.key_rows_low[r*ROW_W +: ROW_W];
    end
  end

  always_comb begin
    col_d        = col_q;
    video_last_d = video_last_q;
    last_or_d    = last_or_q;
    irq_d        = irq_q;
    cass_d       = cass_q;
    rdata        = '0;
    nmi          = 1'b0;
    case (item_i.req_type)
      REQ_READ: begin
        case (item_i.port_addr)
          PORT_ROW_HI: rdata = {4'h0, sel_row[7:4]};
          PORT_ROW_LO: rdata = {NIBBLE_ONES, sel_row[3:0]};
          PORT_MODS:   rdata = {NIBBLE_ONES, 1'b0, item_i.modifier_keys};
          default:     rdata = '0;
        endcase
      end
      REQ_WRITE: begin
        case (item_i.port_addr)
          PORT_ROW_LO: begin
            col_d = item_i.write_data[3:0];
            irq_d = 1'b0;
          end
          PORT_CASS: cass_d = item_i.write_data[0];
          default: ;
        endcase
      end
      REQ_VIDEO: begin
        nmi          = item_i.video_int_level & ~video_last_q;
        video_last_d = item_i.video_int_level;
        if (col_q == COL_SCAN) begin
          if ((any_key != '0) && (any_key != last_or_q)) begin
            irq_d = 1'b1;
          end
          last_or_d = any_key;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q        <= '0;
      video_last_q <= 1'b0;
      last_or_q    <= '0;
      irq_q        <= 1'b0;
      cass_q       <= 1'b0;
    end else if (step_i) begin
      col_q        <= col_d;
      video_last_q <= video_last_d;
      last_or_q    <= last_or_d;
      irq_q        <= irq_d;
      cass_q       <= cass_d;
    end
  end

  assign result_o = '{read_data: rdata, key_irq: irq_d, nmi_pulse: nmi, cass_motor: cass_d};

  `KBIO_ASSERT_NEXT(a_col_write_clears_irq, clk_i, rst_ni,
    step_i && (item_i.req_type == REQ_WRITE) && (item_i.port_addr == PORT_ROW_LO),
    !irq_q)
  `KBIO_ASSERT_NEXT(a_state_holds_when_idle, clk_i, rst_ni,
    !step_i, $stable(col_q) && $stable(irq_q) && $stable(cass_q))
  `KBIO_ASSERT_NOW(a_nmi_only_on_rise, clk_i, rst_ni,
    result_o.nmi_pulse,
    (item_i.req_type == REQ_VIDEO) && item_i.video_int_level && !video_last_q)

endmodule

`default_nettype wire

>>> tb/kbio_port_checker.sv
// ----------------------------------------------------------------------------
// Keyboard matrix I/O port result checker
// Watches the request and result channels, predicts the result of every
// accepted request beat and compares each result beat with the oldest one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kbio_port_checker (
  input  logic clk_i,
  input  logic rst_ni,
  kbio_in_if   req_mon,
  kbio_out_if  res_mon,
  output int   mismatch_count,
  output int   pending_count
);
  import kbio_pkg::*;

  // Predicted copy of the port state.
  logic [3:0] col_sel;
  logic       video_prev;
  logic [7:0] keys_or_prev;
  logic       irq_level;
  logic [3:0] cass_nibble;

  out_item_t  awaited_results[$];
  in_item_t   seen_req;
  out_item_t  seen_res;
  out_item_t  oldest_res;
  out_item_t  next_res;

  function automatic logic [7:0] row_pick(input logic [3:0] idx, input in_item_t b);
    if (idx < 4'd8) begin
      return b.key_rows_low[idx*8 +: 8];
    end
    if (idx == 4'd8) begin
      return b.key_row_eight;
    end
    if (idx == 4'd9) begin
      return {4'h0, b.key_row_nine};
    end
    return 8'h00;
  endfunction

  task automatic compute_port_result(input in_item_t b, output out_item_t r);
    logic [7:0] row;
    logic [7:0] any_keys;
    r = '0;
    row = row_pick(col_sel, b);
    case (b.req_type)
      REQ_READ: begin
        case (b.port_addr)
          PORT_ROW_HI: begin
            if (col_sel <= 4'd8) begin
              r.read_data = {4'h0, row[7:4]};
            end
          end
          PORT_ROW_LO: r.read_data = {NIBBLE_ONES, (col_sel <= 4'd9) ? row[3:0] : 4'h0};
          PORT_MODS:   r.read_data = {NIBBLE_ONES, 1'b0, b.modifier_keys};
          default:     r.read_data = 8'h00;
        endcase
      end
      REQ_WRITE: begin
        if (b.port_addr == PORT_ROW_LO) begin
          col_sel   = b.write_data[3:0];
          irq_level = 1'b0;
        end else if (b.port_addr == PORT_CASS) begin
          cass_nibble = b.write_data[3:0];
        end
      end
      REQ_VIDEO: begin
        r.nmi_pulse = b.video_int_level & ~video_prev;
        video_prev  = b.video_int_level;
        if (col_sel == COL_SCAN) begin
          any_keys = b.key_row_eight;
          for (int i = 0; i < ROWS_LOW_N; i++) begin
            any_keys = any_keys | b.key_rows_low[i*8 +: 8];
          end
          if (any_keys != 8'h00 && any_keys != keys_or_prev) begin
            irq_level = 1'b1;
          end
          keys_or_prev = any_keys;
        end
      end
      default: ;
    endcase
    r.key_irq    = irq_level;
    r.cass_motor = cass_nibble[0];
  endtask

  task automatic note_mismatch(input string what, input out_item_t want, input out_item_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %s: exp rd=%02h irq=%b nmi=%b motor=%b, got rd=%02h irq=%b nmi=%b motor=%b",
               $realtime, what, want.read_data, want.key_irq, want.nmi_pulse, want.cass_motor,
               got.read_data, got.key_irq, got.nmi_pulse, got.cass_motor);
    end
  endtask

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_sel       = 4'h0;
      video_prev    = 1'b0;
      keys_or_prev  = 8'h00;
      irq_level     = 1'b0;
      cass_nibble   = 4'h0;
      awaited_results.delete();
      pending_count = 0;
    end else begin
      // The result of a beat is never accepted on the edge that takes the beat,
      // so the result side is handled first.
      if (res_mon.valid && res_mon.ready) begin
        seen_res.read_data  = res_mon.read_data;
        seen_res.key_irq    = res_mon.key_irq;
        seen_res.nmi_pulse  = res_mon.nmi_pulse;
        seen_res.cass_motor = res_mon.cass_motor;
        if (awaited_results.size() == 0) begin
          note_mismatch("result beat with nothing awaited", '0, seen_res);
        end else begin
          oldest_res = awaited_results.pop_front();
          if (seen_res.read_data !== oldest_res.read_data ||
              seen_res.key_irq !== oldest_res.key_irq ||
              seen_res.nmi_pulse !== oldest_res.nmi_pulse ||
              seen_res.cass_motor !== oldest_res.cass_motor) begin
            note_mismatch("result beat differs", oldest_res, seen_res);
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        seen_req.req_type        = req_e'(req_mon.req_type);
        seen_req.port_addr       = req_mon.port_addr;
        seen_req.write_data      = req_mon.write_data;
        seen_req.video_int_level = req_mon.video_int_level;
        seen_req.key_rows_low    = req_mon.key_rows_low;
        seen_req.key_row_eight   = req_mon.key_row_eight;
        seen_req.key_row_nine    = req_mon.key_row_nine;
        seen_req.modifier_keys   = req_mon.modifier_keys;
        compute_port_result(seen_req, next_res);
        awaited_results.push_back(next_res);
      end
      pending_count = awaited_results.size();
    end
  end

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// Keyboard matrix I/O port testbench
// Drives directed and random port reads, writes and video line samples with
// random idle cycles on both channels, and reports the checker's verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import kbio_pkg::*;

  localparam logic [7:0] PORT_CASS_DATA = 8'h60;
  localparam logic [7:0] PORT_SPARE     = 8'h30;
  localparam int         BEAT_TARGET    = 1650;
  localparam int         STALL_LIMIT    = 2000;

  logic clk_i;
  logic rst_ni;
  logic steady;
  int   beats_sent;
  int   stall_cycles;
  int   next_drain;
  int   mismatch_count;
  int   pending_count;

  kbio_in_if  req_ch();
  kbio_out_if res_ch();

  keyboard_matrix_io_port DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_ch),
    .out_o  (res_ch)
  );

  kbio_port_checker checker_inst (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_mon        (req_ch),
    .res_mon        (res_ch),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    res_ch.ready <= steady || ($urandom_range(99) >= 35);
  end

  // Ends the run if neither channel moves a beat for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Mostly zero or sparse rows, so that the any-key OR of the scan changes
  // between zero and a few distinct values.
  function automatic in_item_t rand_beat(input req_e req, input logic [7:0] port,
                                         input logic [7:0] data);
    in_item_t b;
    int       bit_idx;
    b.req_type        = req;
    b.port_addr       = port;
    b.write_data      = data;
    b.video_int_level = 1'($urandom_range(1));
    b.modifier_keys   = 3'($urandom_range(7));
    b.key_rows_low    = '0;
    b.key_row_eight   = '0;
    b.key_row_nine    = '0;
    case ($urandom_range(3))
      0: ;
      1: begin
        bit_idx = $urandom_range(75);
        if (bit_idx < 64) begin
          b.key_rows_low[bit_idx] = 1'b1;
        end else if (bit_idx < 72) begin
          b.key_row_eight[bit_idx-64] = 1'b1;
        end else begin
          b.key_row_nine[bit_idx-72] = 1'b1;
        end
      end
      2: begin
        b.key_rows_low  = {$urandom, $urandom};
        b.key_row_eight = 8'($urandom);
        b.key_row_nine  = 4'($urandom);
      end
      default: begin
        b.key_rows_low  = {$urandom & $urandom, $urandom & $urandom};
        b.key_row_eight = 8'($urandom & $urandom);
        b.key_row_nine  = 4'($urandom & $urandom);
      end
    endcase
    return b;
  endfunction

  function automatic logic [7:0] pick_port();
    case ($urandom_range(6))
      0:       return PORT_CASS;
      1:       return PORT_ROW_HI;
      2:       return PORT_ROW_LO;
      3:       return PORT_MODS;
      4:       return PORT_CASS_DATA;
      default: return 8'($urandom);
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat moved.
  task automatic drive_beat(input in_item_t b);
    if (!steady) begin
      while ($urandom_range(99) < 35) begin
        req_ch.valid <= 1'b0;
        @(negedge clk_i);
      end
    end
    req_ch.valid           <= 1'b1;
    req_ch.req_type        <= b.req_type;
    req_ch.port_addr       <= b.port_addr;
    req_ch.write_data      <= b.write_data;
    req_ch.video_int_level <= b.video_int_level;
    req_ch.key_rows_low    <= b.key_rows_low;
    req_ch.key_row_eight   <= b.key_row_eight;
    req_ch.key_row_nine    <= b.key_row_nine;
    req_ch.modifier_keys   <= b.modifier_keys;
    @(posedge clk_i);
    while (!req_ch.ready) begin
      @(posedge clk_i);
    end
    beats_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_req(input req_e req, input logic [7:0] port, input logic [7:0] data);
    drive_beat(rand_beat(req, port, data));
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (pending_count != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic run_directed();
    in_item_t b;
    b = rand_beat(REQ_READ, PORT_MODS, 8'h00);
    b.modifier_keys = 3'd0;
    drive_beat(b);
    b.modifier_keys = 3'd7;
    drive_beat(b);
    send_req(REQ_WRITE, PORT_ROW_LO, 8'h00);
    b = rand_beat(REQ_READ, PORT_ROW_HI, 8'h00);
    b.key_rows_low = '1;
    drive_beat(b);
    b = rand_beat(REQ_READ, PORT_ROW_LO, 8'h00);
    b.key_rows_low = '0;
    drive_beat(b);
    send_req(REQ_WRITE, PORT_ROW_LO, 8'hF8);
    b = rand_beat(REQ_READ, PORT_ROW_HI, 8'h00);
    b.key_row_eight = 8'hA5;
    drive_beat(b);
    b.port_addr = PORT_ROW_LO;
    drive_beat(b);
    send_req(REQ_WRITE, PORT_ROW_LO, 8'h09);
    b = rand_beat(REQ_READ, PORT_ROW_HI, 8'h00);
    b.key_row_nine = 4'hF;
    drive_beat(b);
    b.port_addr = PORT_ROW_LO;
    drive_beat(b);
    send_req(REQ_WRITE, PORT_ROW_LO, 8'h0C);
    send_req(REQ_READ, PORT_ROW_LO, 8'h00);
    // Cassette motor on and off; unmapped ports both ways.
    send_req(REQ_WRITE, PORT_CASS, 8'hFF);
    send_req(REQ_WRITE, PORT_SPARE, 8'hFE);
    send_req(REQ_READ, PORT_CASS_DATA, 8'h00);
    send_req(REQ_READ, 8'hFF, 8'h00);
    send_req(REQ_WRITE, PORT_CASS, 8'hFE);
    send_req(REQ_NONE, PORT_ROW_LO, 8'h0F);
    // Key IRQ: no keys, a key, the same key, clear, same again, another key.
    send_req(REQ_WRITE, PORT_ROW_LO, 8'h0F);
    b = rand_beat(REQ_VIDEO, 8'h00, 8'h00);
    b.key_rows_low    = '0;
    b.key_row_eight   = '0;
    b.video_int_level = 1'b0;
    drive_beat(b);
    b.key_row_eight   = 8'h80;
    b.video_int_level = 1'b1;
    drive_beat(b);
    drive_beat(b);
    send_req(REQ_WRITE, PORT_ROW_LO, 8'hFF);
    b.video_int_level = 1'b0;
    drive_beat(b);
    b.key_rows_low = 64'h0100_0000_0000_0000;
    drive_beat(b);
  endtask

  task automatic run_random();
    logic [3:0] col;
    while (beats_sent < BEAT_TARGET) begin
      steady = (beats_sent >= 600 && beats_sent < 900);
      case ($urandom_range(9))
        0, 1, 2: begin
          col = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(9));
          send_req(REQ_WRITE, PORT_ROW_LO, {4'($urandom), col});
          repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(2))
              0:       send_req(REQ_READ, PORT_ROW_HI, 8'($urandom));
              1:       send_req(REQ_READ, PORT_ROW_LO, 8'($urandom));
              default: send_req(REQ_READ, PORT_MODS, 8'($urandom));
            endcase
          end
        end
        3, 4, 5: begin
          send_req(REQ_WRITE, PORT_ROW_LO, {4'($urandom), COL_SCAN});
          repeat ($urandom_range(3, 8)) begin
            if ($urandom_range(4) == 0) begin
              send_req(REQ_READ, pick_port(), 8'($urandom));
            end else begin
              send_req(REQ_VIDEO, 8'($urandom), 8'($urandom));
            end
          end
        end
        6: send_req(REQ_WRITE, PORT_CASS, 8'($urandom));
        7: send_req(REQ_VIDEO, 8'($urandom), 8'($urandom));
        default: send_req(req_e'($urandom_range(3)), pick_port(), 8'($urandom));
      endcase
      if (beats_sent >= next_drain) begin
        wait_drained();
        next_drain += 400;
      end
    end
  endtask

  initial begin
    clk_i                  = 1'b0;
    rst_ni                 = 1'b0;
    steady                 = 1'b0;
    beats_sent             = 0;
    stall_cycles           = 0;
    next_drain             = 400;
    req_ch.valid           = 1'b0;
    req_ch.req_type        = REQ_READ;
    req_ch.port_addr       = '0;
    req_ch.write_data      = '0;
    req_ch.video_int_level = 1'b0;
    req_ch.key_rows_low    = '0;
    req_ch.key_row_eight   = '0;
    req_ch.key_row_nine    = '0;
    req_ch.modifier_keys   = '0;
    res_ch.ready           = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    run_directed();
    wait_drained();
    run_random();
    wait_drained();
    repeat (4) @(negedge clk_i);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
